// ----- src/geometric_algebra_join_meet_defines.svh -----
// Assertion macros for the join and meet block.
`ifndef GEOMETRIC_ALGEBRA_JOIN_MEET_DEFINES_SVH
`define GEOMETRIC_ALGEBRA_JOIN_MEET_DEFINES_SVH

`ifndef ASSERT_OFF
`define GAJM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define GAJM_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define GAJM_ASSERT(lbl, clk, rst, prop, msg)
`define GAJM_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ----- src/gajm_pkg.sv -----
// Shared constants and codes for the join and meet block.
`default_nettype none
package gajm_pkg;
   localparam int DEF_IN_WIDTH  = 16;
   localparam int DEF_FRAC_BITS = 8;
   localparam int OUT_BITS      = 35;
   localparam int N_COMP        = 6;
   localparam int N_LEFT        = 6;
   localparam int N_RIGHT       = 4;
   localparam int N_TERMS       = 3;
   localparam int KIND_W        = 3;
   localparam int TYPE_W        = 2;
   localparam int RSP_DATA_W    = ((N_COMP * OUT_BITS + 7) / 8) * 8;

   localparam logic [KIND_W-1:0] KIND_POINT_JOIN_POINT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LINE_JOIN_POINT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PLANE_MEET_PLANE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LINE_MEET_PLANE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DUAL_POINT       = 3'd4;
   localparam logic [KIND_W-1:0] KIND_DUAL_LINE        = 3'd5;
   localparam logic [KIND_W-1:0] KIND_DUAL_PLANE       = 3'd6;

   localparam logic [TYPE_W-1:0] TYPE_POINT = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_LINE  = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_PLANE = 2'd2;
endpackage
`default_nettype wire

// ----- src/geometric_algebra_join_meet.sv -----
// Top level: join, meet and dual of points, lines and planes in fixed point.
`default_nettype none
`include "geometric_algebra_join_meet_defines.svh"
// Takes one operation per cycle while req_tready is high and returns one point,
// line or plane per item. Throughput is one item per clock while rsp_tready is
// high. Each item passes three registers: an operand register, a register after
// the eighteen multipliers, and a result register after the three-term adders.
// Each stage holds only while the stage after it is full and stalled, so bubbles
// collapse and req_tready stays high while any stage has room.
module geometric_algebra_join_meet #(
   parameter int IN_WIDTH  = gajm_pkg::DEF_IN_WIDTH,
   parameter int FRAC_BITS = gajm_pkg::DEF_FRAC_BITS,
   localparam int REQ_DATA_W = ((10 * IN_WIDTH + 7) / 8) * 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // left_c0..left_c5, right_c0..right_c3, zero fill
   input  wire logic [REQ_DATA_W-1:0]          req_tdata,
   // kind
   input  wire logic [gajm_pkg::KIND_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // res_c0..res_c5, zero fill
   output logic [gajm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // result_type
   output logic [gajm_pkg::TYPE_W-1:0]         rsp_tuser
);
   import gajm_pkg::*;

   localparam int PROD_W = 2 * IN_WIDTH;
   localparam int PAD_W  = RSP_DATA_W - N_COMP * OUT_BITS;

   typedef logic signed [IN_WIDTH-1:0] opnd_type;
   typedef logic signed [OUT_BITS-1:0] res_type;

   logic                 s1_valid_ff;
   logic [KIND_W-1:0]    s1_kind_ff;
   opnd_type             s1_left_ff  [N_LEFT];
   opnd_type             s1_right_ff [N_RIGHT];

   logic                 s2_valid_ff;
   res_type              s2_prod_ff  [N_COMP][N_TERMS];
   logic                 s2_neg_ff   [N_COMP][N_TERMS];
   res_type              s2_dual_ff  [N_COMP];
   logic [TYPE_W-1:0]    s2_type_ff;

   logic                 out_valid_ff;
   res_type              out_res_ff  [N_COMP];
   logic [TYPE_W-1:0]    out_type_ff;

   opnd_type             opa [N_COMP][N_TERMS];
   opnd_type             opb [N_COMP][N_TERMS];
   logic                 neg_in  [N_COMP][N_TERMS];
   res_type              prod_in [N_COMP][N_TERMS];
   res_type              dual_in [N_COMP];
   res_type              upv     [N_LEFT];
   logic [TYPE_W-1:0]    type_in;
   res_type              res_in  [N_COMP];

   logic out_load;
   logic s2_load;
   logic s1_load;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign s2_load    = !s2_valid_ff || out_load;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign req_tready = s1_load;

   // select multiplier operands, dual terms and result type per operation
   always_comb begin
      for (int c = 0; c < N_COMP; c++) begin
         for (int t = 0; t < N_TERMS; t++) begin
            opa[c][t]    = '0;
            opb[c][t]    = '0;
            neg_in[c][t] = 1'b0;
         end
         dual_in[c] = '0;
      end
      for (int i = 0; i < N_LEFT; i++) begin
         upv[i] = OUT_BITS'(s1_left_ff[i]) <<< FRAC_BITS;
      end
      type_in = TYPE_POINT;
      case (s1_kind_ff)
         KIND_POINT_JOIN_POINT: begin
            type_in = TYPE_LINE;
            opa[0][0] = s1_left_ff[1]; opb[0][0] = s1_right_ff[2];
            opa[0][1] = s1_left_ff[2]; opb[0][1] = s1_right_ff[1]; neg_in[0][1] = 1'b1;
            opa[1][0] = s1_left_ff[2]; opb[1][0] = s1_right_ff[0];
            opa[1][1] = s1_left_ff[0]; opb[1][1] = s1_right_ff[2]; neg_in[1][1] = 1'b1;
            opa[2][0] = s1_left_ff[0]; opb[2][0] = s1_right_ff[1];
            opa[2][1] = s1_left_ff[1]; opb[2][1] = s1_right_ff[0]; neg_in[2][1] = 1'b1;
            opa[3][0] = s1_left_ff[3]; opb[3][0] = s1_right_ff[0];
            opa[3][1] = s1_left_ff[0]; opb[3][1] = s1_right_ff[3]; neg_in[3][1] = 1'b1;
            opa[4][0] = s1_left_ff[3]; opb[4][0] = s1_right_ff[1];
            opa[4][1] = s1_left_ff[1]; opb[4][1] = s1_right_ff[3]; neg_in[4][1] = 1'b1;
            opa[5][0] = s1_left_ff[3]; opb[5][0] = s1_right_ff[2];
            opa[5][1] = s1_left_ff[2]; opb[5][1] = s1_right_ff[3]; neg_in[5][1] = 1'b1;
         end
         KIND_LINE_JOIN_POINT: begin
            type_in = TYPE_PLANE;
            opa[0][0] = s1_left_ff[4]; opb[0][0] = s1_right_ff[2];
            opa[0][1] = s1_left_ff[5]; opb[0][1] = s1_right_ff[1]; neg_in[0][1] = 1'b1;
            opa[0][2] = s1_left_ff[0]; opb[0][2] = s1_right_ff[3];
            opa[1][0] = s1_left_ff[5]; opb[1][0] = s1_right_ff[0];
            opa[1][1] = s1_left_ff[3]; opb[1][1] = s1_right_ff[2]; neg_in[1][1] = 1'b1;
            opa[1][2] = s1_left_ff[1]; opb[1][2] = s1_right_ff[3];
            opa[2][0] = s1_left_ff[3]; opb[2][0] = s1_right_ff[1];
            opa[2][1] = s1_left_ff[4]; opb[2][1] = s1_right_ff[0]; neg_in[2][1] = 1'b1;
            opa[2][2] = s1_left_ff[2]; opb[2][2] = s1_right_ff[3];
            opa[3][0] = s1_left_ff[0]; opb[3][0] = s1_right_ff[0]; neg_in[3][0] = 1'b1;
            opa[3][1] = s1_left_ff[1]; opb[3][1] = s1_right_ff[1]; neg_in[3][1] = 1'b1;
            opa[3][2] = s1_left_ff[2]; opb[3][2] = s1_right_ff[2]; neg_in[3][2] = 1'b1;
         end
         KIND_PLANE_MEET_PLANE: begin
            type_in = TYPE_LINE;
            opa[0][0] = s1_left_ff[0]; opb[0][0] = s1_right_ff[3];
            opa[0][1] = s1_left_ff[3]; opb[0][1] = s1_right_ff[0]; neg_in[0][1] = 1'b1;
            opa[1][0] = s1_left_ff[1]; opb[1][0] = s1_right_ff[3];
            opa[1][1] = s1_left_ff[3]; opb[1][1] = s1_right_ff[1]; neg_in[1][1] = 1'b1;
            opa[2][0] = s1_left_ff[2]; opb[2][0] = s1_right_ff[3];
            opa[2][1] = s1_left_ff[3]; opb[2][1] = s1_right_ff[2]; neg_in[2][1] = 1'b1;
            opa[3][0] = s1_left_ff[2]; opb[3][0] = s1_right_ff[1];
            opa[3][1] = s1_left_ff[1]; opb[3][1] = s1_right_ff[2]; neg_in[3][1] = 1'b1;
            opa[4][0] = s1_left_ff[0]; opb[4][0] = s1_right_ff[2];
            opa[4][1] = s1_left_ff[2]; opb[4][1] = s1_right_ff[0]; neg_in[4][1] = 1'b1;
            opa[5][0] = s1_left_ff[1]; opb[5][0] = s1_right_ff[0];
            opa[5][1] = s1_left_ff[0]; opb[5][1] = s1_right_ff[1]; neg_in[5][1] = 1'b1;
         end
         KIND_LINE_MEET_PLANE: begin
            type_in = TYPE_POINT;
            opa[0][0] = s1_left_ff[1]; opb[0][0] = s1_right_ff[2];
            opa[0][1] = s1_left_ff[2]; opb[0][1] = s1_right_ff[1]; neg_in[0][1] = 1'b1;
            opa[0][2] = s1_left_ff[3]; opb[0][2] = s1_right_ff[3];
            opa[1][0] = s1_left_ff[2]; opb[1][0] = s1_right_ff[0];
            opa[1][1] = s1_left_ff[0]; opb[1][1] = s1_right_ff[2]; neg_in[1][1] = 1'b1;
            opa[1][2] = s1_left_ff[4]; opb[1][2] = s1_right_ff[3];
            opa[2][0] = s1_left_ff[0]; opb[2][0] = s1_right_ff[1];
            opa[2][1] = s1_left_ff[1]; opb[2][1] = s1_right_ff[0]; neg_in[2][1] = 1'b1;
            opa[2][2] = s1_left_ff[5]; opb[2][2] = s1_right_ff[3];
            opa[3][0] = s1_left_ff[3]; opb[3][0] = s1_right_ff[0]; neg_in[3][0] = 1'b1;
            opa[3][1] = s1_left_ff[4]; opb[3][1] = s1_right_ff[1]; neg_in[3][1] = 1'b1;
            opa[3][2] = s1_left_ff[5]; opb[3][2] = s1_right_ff[2]; neg_in[3][2] = 1'b1;
         end
         KIND_DUAL_POINT: begin
            type_in    = TYPE_PLANE;
            dual_in[3] = -upv[3];
         end
         KIND_DUAL_LINE: begin
            type_in    = TYPE_LINE;
            dual_in[0] = -upv[3];
            dual_in[1] = -upv[4];
            dual_in[2] = -upv[5];
         end
         KIND_DUAL_PLANE: begin
            type_in    = TYPE_POINT;
            dual_in[0] = upv[0];
            dual_in[1] = upv[1];
            dual_in[2] = upv[2];
         end
         default: begin
            type_in = TYPE_POINT;
         end
      endcase
   end

   // multiply, extend the full product to the result width
   always_comb begin
      for (int c = 0; c < N_COMP; c++) begin
         for (int t = 0; t < N_TERMS; t++) begin
            prod_in[c][t] = OUT_BITS'(PROD_W'(opa[c][t] * opb[c][t]));
         end
      end
   end

   // add the signed terms
   always_comb begin
      for (int c = 0; c < N_COMP; c++) begin
         res_in[c] = s2_dual_ff[c];
         for (int t = 0; t < N_TERMS; t++) begin
            res_in[c] = res_in[c] + (s2_neg_ff[c][t] ? -s2_prod_ff[c][t] : s2_prod_ff[c][t]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_load) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_tvalid) begin
         s1_kind_ff <= req_tuser;
         for (int i = 0; i < N_LEFT; i++) begin
            s1_left_ff[i] <= req_tdata[i*IN_WIDTH +: IN_WIDTH];
         end
         for (int i = 0; i < N_RIGHT; i++) begin
            s1_right_ff[i] <= req_tdata[(N_LEFT+i)*IN_WIDTH +: IN_WIDTH];
         end
      end
      if (s2_load && s1_valid_ff) begin
         s2_type_ff <= type_in;
         for (int c = 0; c < N_COMP; c++) begin
            s2_dual_ff[c] <= dual_in[c];
            for (int t = 0; t < N_TERMS; t++) begin
               s2_prod_ff[c][t] <= prod_in[c][t];
               s2_neg_ff[c][t]  <= neg_in[c][t];
            end
         end
      end
      if (out_load && s2_valid_ff) begin
         out_type_ff <= s2_type_ff;
         for (int c = 0; c < N_COMP; c++) begin
            out_res_ff[c] <= res_in[c];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_type_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_res_ff[5], out_res_ff[4], out_res_ff[3],
                        out_res_ff[2], out_res_ff[1], out_res_ff[0]};

   `GAJM_ASSERT(a_accept_lands, clock, reset, (req_tvalid && req_tready) |=> s1_valid_ff, "accepted item not captured")
   `GAJM_ASSERT(a_ready_on_room, clock, reset, (!s1_valid_ff || !s2_valid_ff || !out_valid_ff) |-> req_tready, "ready low with room in pipeline")
   `GAJM_ASSERT(a_mid_holds, clock, reset, (s2_valid_ff && !out_load) |=> s2_valid_ff, "stalled item dropped from product stage")
   `GAJM_ASSERT(a_spare_zero, clock, reset, (rsp_tvalid && rsp_tuser != TYPE_LINE) |-> (out_res_ff[4] == '0 && out_res_ff[5] == '0), "point or plane with nonzero line components")
endmodule
`default_nettype wire

// ----- tb/tb_geometric_algebra_join_meet.sv -----
// Self-checking testbench for the join, meet and dual block over its stream ports.
module tb_geometric_algebra_join_meet;
   timeunit 1ns;
   timeprecision 1ps;
   import gajm_pkg::*;

   localparam int                 IN_W        = DEF_IN_WIDTH;
   localparam int                 REQ_W       = ((10 * IN_W + 7) / 8) * 8;
   localparam logic [KIND_W-1:0]  KIND_UNUSED = 3'd7;
   localparam int                 N_RANDOM    = 1250;
   localparam int                 IDLE_LIMIT  = 2000;
   localparam int                 HOLD_CYCLES = 80;
   localparam int                 MAX_REPORTS = 10;

   typedef struct packed {
      logic [KIND_W-1:0]              kind;
      logic [N_RIGHT-1:0][IN_W-1:0]   right;
      logic [N_LEFT-1:0][IN_W-1:0]    left;
   } op_type;

   typedef struct packed {
      logic [TYPE_W-1:0]              rtype;
      logic [N_COMP-1:0][OUT_BITS-1:0] comp;
   } shape_type;

   typedef struct packed {
      logic   drain;
      op_type op;
   } pending_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [TYPE_W-1:0]     rsp_tuser;

   pending_type pending_ops[$];
   shape_type   expected_shapes[$];

   logic      req_taken = 1'b0;
   int        mismatches = 0;
   int        results_seen = 0;
   int        idle_cycles = 0;
   int        burst_left = 1;
   int        gap_left = 0;
   int        rx_cycle = 0;
   int        rx_mode = 0;
   int        hold_left = 0;
   logic      hold_done = 1'b0;
   op_type    seen_op;
   shape_type want;
   shape_type got;
   logic [OUT_BITS-1:0] want_v;
   logic [OUT_BITS-1:0] got_v;

   geometric_algebra_join_meet u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic shape_type geometry_of(op_type op);
      longint a [N_LEFT];
      longint b [N_RIGHT];
      longint r [N_COMP];
      shape_type s;
      for (int i = 0; i < N_LEFT; i++) a[i] = longint'($signed(op.left[i]));
      for (int i = 0; i < N_RIGHT; i++) b[i] = longint'($signed(op.right[i]));
      for (int i = 0; i < N_COMP; i++) r[i] = 0;
      s.rtype = TYPE_POINT;
      case (op.kind)
         KIND_POINT_JOIN_POINT: begin
            s.rtype = TYPE_LINE;
            r[0] = a[1] * b[2] - a[2] * b[1];
            r[1] = a[2] * b[0] - a[0] * b[2];
            r[2] = a[0] * b[1] - a[1] * b[0];
            r[3] = a[3] * b[0] - a[0] * b[3];
            r[4] = a[3] * b[1] - a[1] * b[3];
            r[5] = a[3] * b[2] - a[2] * b[3];
         end
         KIND_LINE_JOIN_POINT: begin
            s.rtype = TYPE_PLANE;
            r[0] = a[4] * b[2] - a[5] * b[1] + a[0] * b[3];
            r[1] = a[5] * b[0] - a[3] * b[2] + a[1] * b[3];
            r[2] = a[3] * b[1] - a[4] * b[0] + a[2] * b[3];
            r[3] = -(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
         end
         KIND_PLANE_MEET_PLANE: begin
            s.rtype = TYPE_LINE;
            r[0] = a[0] * b[3] - a[3] * b[0];
            r[1] = a[1] * b[3] - a[3] * b[1];
            r[2] = a[2] * b[3] - a[3] * b[2];
            r[3] = a[2] * b[1] - a[1] * b[2];
            r[4] = a[0] * b[2] - a[2] * b[0];
            r[5] = a[1] * b[0] - a[0] * b[1];
         end
         KIND_LINE_MEET_PLANE: begin
            s.rtype = TYPE_POINT;
            r[0] = a[1] * b[2] - a[2] * b[1] + a[3] * b[3];
            r[1] = a[2] * b[0] - a[0] * b[2] + a[4] * b[3];
            r[2] = a[0] * b[1] - a[1] * b[0] + a[5] * b[3];
            r[3] = -(a[3] * b[0] + a[4] * b[1] + a[5] * b[2]);
         end
         KIND_DUAL_POINT: begin
            s.rtype = TYPE_PLANE;
            r[3] = -(a[3] <<< DEF_FRAC_BITS);
         end
         KIND_DUAL_LINE: begin
            s.rtype = TYPE_LINE;
            r[0] = -(a[3] <<< DEF_FRAC_BITS);
            r[1] = -(a[4] <<< DEF_FRAC_BITS);
            r[2] = -(a[5] <<< DEF_FRAC_BITS);
         end
         KIND_DUAL_PLANE: begin
            s.rtype = TYPE_POINT;
            r[0] = a[0] <<< DEF_FRAC_BITS;
            r[1] = a[1] <<< DEF_FRAC_BITS;
            r[2] = a[2] <<< DEF_FRAC_BITS;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < N_COMP; i++) s.comp[i] = r[i][OUT_BITS-1:0];
      return s;
   endfunction

   function automatic logic [IN_W-1:0] rand_q88();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3, 4, 5: return 16'($urandom_range(0, 511) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic op_type rand_op(logic [KIND_W-1:0] kind);
      op_type op;
      op.kind = kind;
      for (int i = 0; i < N_LEFT; i++) op.left[i] = rand_q88();
      for (int i = 0; i < N_RIGHT; i++) op.right[i] = rand_q88();
      return op;
   endfunction

   task automatic queue_op(op_type op, logic drain);
      pending_type p;
      p.drain = drain;
      p.op    = op;
      pending_ops.push_back(p);
   endtask

   // sender: bursts of transfers separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() != 0 &&
                      (!pending_ops[0].drain || expected_shapes.size() == 0)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {pending_ops[0].op.right, pending_ops[0].op.left};
            req_tuser  <= pending_ops[0].op.kind;
            void'(pending_ops.pop_front());
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern that changes mode, plus one long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle = rx_cycle + 1;
         if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
         if (!hold_done && results_seen >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (rx_cycle % 4) != 0;
               default: rsp_tready <= $urandom_range(0, 7) != 0;
            endcase
         end
      end
   end

   // monitor: check each result transfer, predict each accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen = results_seen + 1;
            if (expected_shapes.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result transfer: type %0d", rsp_tuser);
            end else begin
               want = expected_shapes.pop_front();
               got.rtype = rsp_tuser;
               got.comp  = rsp_tdata[N_COMP*OUT_BITS-1:0];
               for (int f = 0; f <= N_COMP; f++) begin
                  if (f == 0) begin
                     want_v = OUT_BITS'(want.rtype);
                     got_v  = OUT_BITS'(got.rtype);
                  end else begin
                     want_v = want.comp[f-1];
                     got_v  = got.comp[f-1];
                  end
                  if (got_v !== want_v) begin
                     mismatches = mismatches + 1;
                     if (mismatches <= MAX_REPORTS)
                        $display("result %0d field %0d: expected %0d, got %0d",
                                 results_seen, f, $signed(want_v), $signed(got_v));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            seen_op.kind = req_tuser;
            {seen_op.right, seen_op.left} = req_tdata;
            expected_shapes.push_back(geometry_of(seen_op));
         end
         req_taken <= req_tvalid && req_tready;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      op_type op;
      logic drain;
      for (int k = 0; k <= 7; k++) queue_op(rand_op(KIND_W'(k)), 1'b0);
      for (int k = 0; k <= 6; k++) begin
         op.kind  = KIND_W'(k);
         op.left  = {N_LEFT{16'h8000}};
         op.right = {N_RIGHT{16'h7fff}};
         queue_op(op, 1'b0);
         op.left  = {N_LEFT{16'h7fff}};
         op.right = {N_RIGHT{16'h8000}};
         queue_op(op, 1'b0);
      end
      // coincident points
      op = rand_op(KIND_POINT_JOIN_POINT);
      for (int i = 0; i < N_RIGHT; i++) op.right[i] = op.left[i];
      queue_op(op, 1'b0);
      // parallel planes
      op = rand_op(KIND_PLANE_MEET_PLANE);
      for (int i = 0; i < N_RIGHT; i++) op.right[i] = op.left[i];
      queue_op(op, 1'b0);
      // line parallel to a plane
      op = rand_op(KIND_LINE_MEET_PLANE);
      op.left[3]  = 16'h0100;
      op.left[4]  = 16'h0000;
      op.left[5]  = 16'h0000;
      op.right[0] = 16'h0000;
      op.right[1] = 16'h0000;
      op.right[2] = 16'h0100;
      queue_op(op, 1'b0);

      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(0, 15) == 0)
            op = rand_op(KIND_UNUSED);
         else
            op = rand_op(KIND_W'($urandom_range(0, 6)));
         drain = (n == 600) || ($urandom_range(0, 299) == 0);
         queue_op(op, drain);
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_ops.size() != 0 || req_tvalid || expected_shapes.size() != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);

      if (mismatches == 0 && expected_shapes.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+src
src/gajm_pkg.sv
src/geometric_algebra_join_meet.sv
tb/tb_geometric_algebra_join_meet.sv
